/* rtl/core/dns_failure_counter_table_macros.svh */
// ----------------------------------------------------------------------------
// dns failure counter table assertion macros
// clocked implication checks, disabled while the active-low reset is low
// ----------------------------------------------------------------------------
`ifndef DNS_FAILURE_COUNTER_TABLE_MACROS_SVH
`define DNS_FAILURE_COUNTER_TABLE_MACROS_SVH

// overlapping implication
`define DFCT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DFCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/dfct_pkg.sv */
// ----------------------------------------------------------------------------
// dfct_pkg
// types and constants shared by the dns failure counter table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfct_pkg;

    localparam logic [15:0] C_DNS_PORT_RST = 16'd53;
    localparam logic [15:0] C_ETH_IPV4     = 16'h0800;
    localparam logic [7:0]  C_PROTO_UDP    = 8'd17;
    localparam logic [3:0]  C_RCODE_OK     = 4'd0;
    localparam logic [31:0] C_COUNT_MAX    = 32'hFFFF_FFFF;
    localparam logic [31:0] C_COUNT_ONE    = 32'd1;

    typedef struct packed {
        logic [15:0] eth_type;
        logic [7:0]  ip_proto;
        logic [15:0] udp_src_port;
        logic [31:0] dest_address;
        logic [15:0] dns_flags;
    } t_in_word;

    typedef struct packed {
        logic        is_dns_response;
        logic        entry_found;
        logic        inserted;
        logic        evicted;
        logic [31:0] count_after;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic update;
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/dns_failure_counter_table.sv */
// ----------------------------------------------------------------------------
// dns_failure_counter_table
// per-address dns failure counts in a fully associative lru table
// ----------------------------------------------------------------------------
// channel  direction  word                  handshake
// in       input      i_in_word (t_in_word)   i_in_valid / o_in_stall
// out      output     o_out_word (t_out_word) o_out_valid / i_out_stall
// cfg      input      i_cfg_wr_data (16b)     i_cfg_wr_en
//
// each word is handled in two steps, one word at a time: accept with cam lookup and
// count ram read, then table update into the result register; the registered count
// ram read sets this split; the result shows the cycle after the update, while the next word can be taken
// reset clears valid bits and ranks directly, no clearing pass
// a stalled result holds, and the next update waits until it has left
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dns_failure_counter_table #(
    parameter int ENTRIES = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wr_en,
    input  wire [15:0]           i_cfg_wr_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  dfct_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output dfct_pkg::t_out_word  o_out_word
);

    dfct_pkg::t_cmd cmd;

    dfct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cmd      (cmd)
    );

    dfct_dp #(
        .ENTRIES(ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_word    (i_in_word),
        .o_out_word   (o_out_word)
    );

endmodule

`default_nettype wire

/* rtl/core/dfct_ram.sv */
// ----------------------------------------------------------------------------
// dfct_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_wr_en,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]         i_wr_data,
    input  wire                     i_rd_en,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/core/dfct_ctrl.sv */
// ----------------------------------------------------------------------------
// dfct_ctrl
// sequencer: accept, table update, result hold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfct_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire           i_out_stall,
    output dfct_pkg::t_cmd o_cmd
);

    dfct_pkg::t_state r_state;
    dfct_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dfct_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.update = 1'b0;
        o_in_stall   = 1'b1;
        n_out_valid  = r_out_valid && i_out_stall;
        unique case (r_state)
            dfct_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dfct_pkg::ST_UPDATE;
                end
            end
            dfct_pkg::ST_UPDATE: begin
                // wait while the result register still holds a stalled word
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.update = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = dfct_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dfct_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/core/dfct_dp.sv */
// ----------------------------------------------------------------------------
// dfct_dp
// key cam, recency ranks, count ram and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfct_dp #(
    parameter int ENTRIES = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  dfct_pkg::t_cmd       i_cmd,
    input  wire                  i_cfg_wr_en,
    input  wire [15:0]           i_cfg_wr_data,
    input  dfct_pkg::t_in_word   i_in_word,
    output dfct_pkg::t_out_word  o_out_word
);

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] C_AGE_OLDEST = AW'(ENTRIES - 1);

    logic [15:0]          r_dns_port;
    dfct_pkg::t_in_word   r_in;
    logic                 r_qual;
    logic                 r_hit;
    logic [AW-1:0]        r_hit_idx;
    logic [ENTRIES-1:0]   r_hit_vec;
    logic [ENTRIES-1:0]   r_valid;
    logic [ENTRIES-1:0]   n_valid;
    logic [AW-1:0]        r_age [ENTRIES];
    logic [AW-1:0]        n_age [ENTRIES];
    logic [31:0]          r_key [ENTRIES];
    dfct_pkg::t_out_word  r_out;
    dfct_pkg::t_out_word  n_out;

    logic                 qual;
    logic [ENTRIES-1:0]   match;
    logic [AW-1:0]        hit_idx;
    logic [31:0]          cur_count;
    logic [31:0]          new_count;
    logic [3:0]           rcode;
    logic                 do_hit;
    logic                 do_ins;
    logic [AW-1:0]        hit_age;
    logic [ENTRIES-1:0]   free_vec;
    logic [AW-1:0]        free_idx;
    logic                 any_free;
    logic [ENTRIES-1:0]   victim_vec;
    logic [AW-1:0]        victim_idx;
    logic [ENTRIES-1:0]   slot_vec;
    logic [AW-1:0]        wr_idx;
    logic [31:0]          wr_data;
    logic                 wr_en;

    // lookup on the incoming word
    assign qual = (i_in_word.eth_type == dfct_pkg::C_ETH_IPV4)
               && (i_in_word.ip_proto == dfct_pkg::C_PROTO_UDP)
               && (i_in_word.udp_src_port == r_dns_port);

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_key[i] == i_in_word.dest_address);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = AW'(i);
            end
        end
    end

    dfct_ram #(
        .WIDTH(32),
        .DEPTH(ENTRIES)
    ) u_count_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_idx),
        .i_wr_data(wr_data),
        .i_rd_en  (i_cmd.load),
        .i_rd_addr(hit_idx),
        .o_rd_data(cur_count)
    );

    // update on the latched word
    assign rcode  = r_in.dns_flags[3:0];
    assign do_hit = r_qual && r_hit;
    assign do_ins = r_qual && !r_hit && (rcode != dfct_pkg::C_RCODE_OK);

    always_comb begin
        if (rcode == dfct_pkg::C_RCODE_OK) begin
            new_count = (cur_count != '0) ? cur_count - 32'd1 : cur_count;
        end else begin
            new_count = (cur_count != dfct_pkg::C_COUNT_MAX) ? cur_count + 32'd1 : cur_count;
        end
    end

    always_comb begin
        hit_age    = '0;
        free_idx   = '0;
        victim_idx = '0;
        free_vec   = '0;
        victim_vec = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_age = hit_age | (r_hit_vec[i] ? r_age[i] : '0);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = AW'(i);
            end
            if (r_valid[i] && (r_age[i] == C_AGE_OLDEST)) begin
                victim_idx = AW'(i);
            end
        end
        free_vec[free_idx]     = 1'b1;
        victim_vec[victim_idx] = 1'b1;
    end

    assign any_free = ~&r_valid;
    assign slot_vec = any_free ? free_vec : victim_vec;
    assign wr_idx   = r_hit ? r_hit_idx : (any_free ? free_idx : victim_idx);
    assign wr_data  = do_hit ? new_count : dfct_pkg::C_COUNT_ONE;
    assign wr_en    = i_cmd.update && (do_hit || do_ins);

    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < ENTRIES; i++) begin
            n_age[i] = r_age[i];
        end
        if (i_cmd.update && do_hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_hit_vec[i]) begin
                    n_age[i] = '0;
                end else if (r_valid[i] && (r_age[i] < hit_age)) begin
                    n_age[i] = r_age[i] + AW'(1);
                end
            end
        end else if (i_cmd.update && do_ins) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_vec[i]) begin
                    n_age[i]   = '0;
                    n_valid[i] = 1'b1;
                end else if (r_valid[i]) begin
                    n_age[i] = r_age[i] + AW'(1);
                end
            end
        end
    end

    always_comb begin
        n_out                 = '0;
        n_out.is_dns_response = r_qual;
        n_out.entry_found     = do_hit;
        n_out.inserted        = do_ins;
        n_out.evicted         = do_ins && !any_free;
        if (do_hit) begin
            n_out.count_after = new_count;
        end else if (do_ins) begin
            n_out.count_after = dfct_pkg::C_COUNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dns_port <= dfct_pkg::C_DNS_PORT_RST;
            r_valid    <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_dns_port <= i_cfg_wr_data;
            end
            r_valid <= n_valid;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= n_age[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in      <= i_in_word;
            r_qual    <= qual;
            r_hit     <= |match;
            r_hit_idx <= hit_idx;
            r_hit_vec <= match;
        end
        if (i_cmd.update) begin
            r_out <= n_out;
            if (do_ins) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_vec[i]) begin
                        r_key[i] <= r_in.dest_address;
                    end
                end
            end
        end
    end

    assign o_out_word = r_out;

endmodule

`default_nettype wire

/* rtl/core/dfct_chk.sv */
// ----------------------------------------------------------------------------
// dfct_chk
// port-level checks for the dns failure counter table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "dns_failure_counter_table_macros.svh"

module dfct_chk (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 i_in_stall,
    input wire                 i_out_valid,
    input wire                 i_out_stall,
    input dfct_pkg::t_out_word i_out_word
);

    `DFCT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_word), "stalled result word changed")
    `DFCT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall, "input taken while word in flight")
    `DFCT_ASSERT_NOW(a_non_dns_zero, i_clk, i_rst_n, i_out_valid && !i_out_word.is_dns_response, !i_out_word.entry_found && !i_out_word.inserted && !i_out_word.evicted && (i_out_word.count_after == 32'd0), "non dns word has flags set")
    `DFCT_ASSERT_NOW(a_insert_shape, i_clk, i_rst_n, i_out_valid && (i_out_word.inserted || i_out_word.evicted), i_out_word.inserted && !i_out_word.entry_found && (i_out_word.count_after == 32'd1), "bad insert result")

endmodule

bind dns_failure_counter_table dfct_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .i_in_stall (o_in_stall),
    .i_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .i_out_word (o_out_word)
);

`default_nettype wire
